// ----- rtl/line_follow_steering_pid_assert.svh -----
// Assertion macros used by the sequencing module of the steering controller.
`ifndef LINE_FOLLOW_STEERING_PID_ASSERT_SVH
`define LINE_FOLLOW_STEERING_PID_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define LFSP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfsp: same-cycle check failed");
// Next-cycle implication, checked on every rising clock edge outside reset.
`define LFSP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfsp: next-cycle check failed");
`else
`define LFSP_ASSERT_IMP(lbl, ante, cons)
`define LFSP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/lfsp_pkg.sv -----
// Shared types, widths and constants of the line-follow steering controller.
`default_nettype none

package lfsp_pkg;

    // Port widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Field widths
    localparam int LIGHT_W  = 10;
    localparam int ANGLE_W  = 16;
    localparam int LIMIT_W  = 15;
    localparam int SPEED_W  = 8;
    localparam int FRONT_W  = 16;
    localparam int ERR_W    = 11;
    localparam int DIFF_W   = 12;
    localparam int SUM_W    = 32;

    // Datapath widths
    localparam int MUL_A_W  = 25;
    localparam int MUL_B_W  = 32;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int FRAC_W   = 24;
    localparam int GAIN_SH  = 16;
    localparam int TURN_W   = 42;
    localparam int SCALE_W  = 8;
    localparam int SCALED_W = TURN_W + SCALE_W + 1;
    localparam int PWMV_W   = TURN_W + 1;

    // Steering command scale and turn clamp (+-65536.0 in Q.24)
    localparam int     TURN_SCALE = 50;
    localparam longint TURN_LIM   = 64'sd1 <<< 40;

    // On-off front motor PWM magnitude
    localparam int FRONT_PWM = 100;

    typedef enum logic [1:0] {
        MODE_ONOFF_R = 2'd0,
        MODE_ONOFF_L = 2'd1,
        MODE_PID_R   = 2'd2,
        MODE_PID_L   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_THRESHOLD = 3'd1,
        REG_BASE      = 3'd2,
        REG_MAX_LEFT  = 3'd3,
        REG_MAX_RIGHT = 3'd4,
        REG_GAIN_P    = 3'd5,
        REG_GAIN_I    = 3'd6,
        REG_GAIN_D    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        mode_t              mode;
        logic [9:0]         threshold;
        logic signed [7:0]  base_speed;
        logic [14:0]        max_left;
        logic [14:0]        max_right;
        logic [15:0]        gain_p;
        logic [23:0]        gain_i;
        logic [15:0]        gain_d;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MP,
        S_MI,
        S_MD,
        S_ACC,
        S_CLAMP,
        S_SCALE,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        MUL_P,
        MUL_I,
        MUL_D
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_clear;
        logic     acc_add;
        logic     clamp;
        logic     scale;
        logic     out_load;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/lfsp_cfg.sv -----
// Configuration register file of the line-follow steering controller.
`default_nettype none

module lfsp_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [lfsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lfsp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output lfsp_pkg::cfg_t                       cfg
);

    lfsp_pkg::cfg_t cfg_reg;

    // Each register keeps only the low bits of the written word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= lfsp_pkg::MODE_PID_R;
            cfg_reg.threshold  <= 10'd512;
            cfg_reg.base_speed <= 8'sd0;
            cfg_reg.max_left   <= 15'd0;
            cfg_reg.max_right  <= 15'd0;
            cfg_reg.gain_p     <= 16'd64;
            cfg_reg.gain_i     <= 24'd0;
            cfg_reg.gain_d     <= 16'd1600;
        end
        else if (cfg_we)
        begin
            case (lfsp_pkg::reg_idx_t'(cfg_index))
                lfsp_pkg::REG_MODE:      cfg_reg.mode       <= lfsp_pkg::mode_t'(cfg_wdata[1:0]);
                lfsp_pkg::REG_THRESHOLD: cfg_reg.threshold  <= cfg_wdata[9:0];
                lfsp_pkg::REG_BASE:      cfg_reg.base_speed <= signed'(cfg_wdata[7:0]);
                lfsp_pkg::REG_MAX_LEFT:  cfg_reg.max_left   <= cfg_wdata[14:0];
                lfsp_pkg::REG_MAX_RIGHT: cfg_reg.max_right  <= cfg_wdata[14:0];
                lfsp_pkg::REG_GAIN_P:    cfg_reg.gain_p     <= cfg_wdata[15:0];
                lfsp_pkg::REG_GAIN_I:    cfg_reg.gain_i     <= cfg_wdata[23:0];
                lfsp_pkg::REG_GAIN_D:    cfg_reg.gain_d     <= cfg_wdata[15:0];
                default:                 cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/lfsp_ctrl.sv -----
// Sequencing state machine and output handshake of the steering controller.
`default_nettype none

`include "line_follow_steering_pid_assert.svh"

module lfsp_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output lfsp_pkg::dp_cmd_t cmd
);

    lfsp_pkg::state_t state_reg;
    lfsp_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || m_ready;

    // State register and output beat valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfsp_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state: one fixed pass through the multiply sequence per beat.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lfsp_pkg::S_IDLE:
            begin
                if (s_valid)
                begin
                    state_next = lfsp_pkg::S_MP;
                end
            end
            lfsp_pkg::S_MP:    state_next = lfsp_pkg::S_MI;
            lfsp_pkg::S_MI:    state_next = lfsp_pkg::S_MD;
            lfsp_pkg::S_MD:    state_next = lfsp_pkg::S_ACC;
            lfsp_pkg::S_ACC:   state_next = lfsp_pkg::S_CLAMP;
            lfsp_pkg::S_CLAMP: state_next = lfsp_pkg::S_SCALE;
            lfsp_pkg::S_SCALE: state_next = lfsp_pkg::S_DONE;
            lfsp_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = lfsp_pkg::S_IDLE;
                end
            end
            default:           state_next = lfsp_pkg::S_IDLE;
        endcase
    end

    // Datapath commands and handshake outputs.
    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = lfsp_pkg::MUL_P;
        s_ready     = 1'b0;
        case (state_reg)
            lfsp_pkg::S_IDLE:
            begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            lfsp_pkg::S_MP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = lfsp_pkg::MUL_P;
            end
            lfsp_pkg::S_MI:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = lfsp_pkg::MUL_I;
                cmd.acc_clear = 1'b1;
            end
            lfsp_pkg::S_MD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = lfsp_pkg::MUL_D;
                cmd.acc_add = 1'b1;
            end
            lfsp_pkg::S_ACC:   cmd.acc_add  = 1'b1;
            lfsp_pkg::S_CLAMP: cmd.clamp    = 1'b1;
            lfsp_pkg::S_SCALE: cmd.scale    = 1'b1;
            lfsp_pkg::S_DONE:  cmd.out_load = out_free;
            default:           cmd          = '0;
        endcase
    end

    // The output beat stays until taken; a new result refills it.
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

    `LFSP_ASSERT_NXT(a_accept_starts, s_valid && s_ready, state_reg == lfsp_pkg::S_MP)
    `LFSP_ASSERT_NXT(a_done_loads, (state_reg == lfsp_pkg::S_DONE) && out_free, out_valid_reg && (state_reg == lfsp_pkg::S_IDLE))
    `LFSP_ASSERT_IMP(a_clamp_order, state_reg == lfsp_pkg::S_CLAMP, $past(state_reg) == lfsp_pkg::S_ACC)

endmodule

`default_nettype wire

// ----- rtl/lfsp_dp.sv -----
// Datapath: error tracking, shared gain multiplier, turn clamp and output shaping.
`default_nettype none

module lfsp_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire lfsp_pkg::dp_cmd_t                cmd,
    input  wire lfsp_pkg::cfg_t                   cfg,
    input  wire logic [lfsp_pkg::IN_DATA_W-1:0]   in_data,
    output logic [lfsp_pkg::OUT_DATA_W-1:0]       out_data,
    output logic                                  out_kind
);

    localparam int EXT_W   = lfsp_pkg::LIMIT_W + 2;
    localparam int SSUM_W  = lfsp_pkg::SUM_W + 2;
    localparam int FQ_W    = lfsp_pkg::SCALED_W - lfsp_pkg::FRAC_W;
    localparam int PQ_W    = lfsp_pkg::PWMV_W - lfsp_pkg::FRAC_W;

    // Input fields
    logic [lfsp_pkg::LIGHT_W-1:0]        in_light;
    logic signed [lfsp_pkg::ANGLE_W-1:0] in_angle;

    // Per-beat working registers
    logic signed [lfsp_pkg::ERR_W-1:0]    e_reg;
    logic signed [lfsp_pkg::DIFF_W-1:0]   diff_reg;
    logic                                 white_reg;
    logic                                 can_left_reg;
    logic                                 can_right_reg;
    logic signed [lfsp_pkg::PROD_W-1:0]   prod_reg;
    logic                                 prod_shift_reg;
    logic signed [lfsp_pkg::ACC_W-1:0]    acc_reg;
    logic signed [lfsp_pkg::TURN_W-1:0]   turn_reg;
    logic signed [lfsp_pkg::SCALED_W-1:0] scaled_reg;

    // Controller state kept across beats
    logic signed [lfsp_pkg::ERR_W-1:0]    prev_reg;
    logic signed [lfsp_pkg::SUM_W-1:0]    sum_reg;

    // Output beat payload
    logic signed [lfsp_pkg::FRONT_W-1:0]  front_reg;
    logic signed [lfsp_pkg::SPEED_W-1:0]  left_reg;
    logic signed [lfsp_pkg::SPEED_W-1:0]  right_reg;
    logic                                 kind_reg;

    // Combinational helpers
    logic                                 is_pid;
    logic                                 left_edge;
    logic signed [lfsp_pkg::ERR_W-1:0]    e_new;
    logic signed [lfsp_pkg::DIFF_W-1:0]   diff_new;
    logic signed [SSUM_W-1:0]             sum_wide;
    logic signed [lfsp_pkg::SUM_W-1:0]    sum_sat;
    logic signed [EXT_W-1:0]              angle_ext;
    logic                                 white_new;
    logic                                 can_left_new;
    logic                                 can_right_new;
    logic signed [lfsp_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [lfsp_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [lfsp_pkg::PROD_W-1:0]   mul_p;
    logic signed [lfsp_pkg::ACC_W-1:0]    prod_wide;
    logic signed [lfsp_pkg::ACC_W-1:0]    prod_term;
    logic signed [lfsp_pkg::ACC_W-1:0]    turn_pre;
    logic signed [lfsp_pkg::ACC_W-1:0]    turn_lim;
    logic signed [lfsp_pkg::ACC_W-1:0]    turn_clamped;
    logic signed [lfsp_pkg::SCALE_W:0]    scale_c;
    logic signed [lfsp_pkg::SCALED_W-1:0] front_adj;
    logic signed [FQ_W-1:0]               front_q;
    logic signed [lfsp_pkg::FRONT_W-1:0]  front_sat;
    logic signed [lfsp_pkg::PWMV_W-1:0]   pwm_t;
    logic signed [lfsp_pkg::PWMV_W-1:0]   pwm_v;
    logic signed [lfsp_pkg::PWMV_W-1:0]   pwm_adj;
    logic signed [PQ_W-1:0]               pwm_q;
    logic signed [lfsp_pkg::SPEED_W-1:0]  pwm_sat;
    logic                                 steer_left;
    logic signed [lfsp_pkg::FRONT_W-1:0]  front_next;
    logic signed [lfsp_pkg::SPEED_W-1:0]  left_next;
    logic signed [lfsp_pkg::SPEED_W-1:0]  right_next;
    logic                                 kind_next;

    assign in_light = in_data[lfsp_pkg::LIGHT_W-1:0];
    assign in_angle = signed'(in_data[lfsp_pkg::LIGHT_W +: lfsp_pkg::ANGLE_W]);

    assign is_pid    = (cfg.mode == lfsp_pkg::MODE_PID_R) || (cfg.mode == lfsp_pkg::MODE_PID_L);
    assign left_edge = (cfg.mode == lfsp_pkg::MODE_ONOFF_L) || (cfg.mode == lfsp_pkg::MODE_PID_L);

    // Error, its change and the saturating trapezoid sum for the incoming beat.
    always_comb
    begin
        e_new    = signed'({1'b0, in_light}) - signed'({1'b0, cfg.threshold});
        diff_new = {e_new[lfsp_pkg::ERR_W-1], e_new} - {prev_reg[lfsp_pkg::ERR_W-1], prev_reg};
        sum_wide = SSUM_W'(sum_reg) + SSUM_W'(e_new) + SSUM_W'(prev_reg);
        if (sum_wide[SSUM_W-1:lfsp_pkg::SUM_W-1] == '0
            || sum_wide[SSUM_W-1:lfsp_pkg::SUM_W-1] == '1)
        begin
            sum_sat = sum_wide[lfsp_pkg::SUM_W-1:0];
        end
        else if (sum_wide[SSUM_W-1])
        begin
            sum_sat = {1'b1, {(lfsp_pkg::SUM_W-1){1'b0}}};
        end
        else
        begin
            sum_sat = {1'b0, {(lfsp_pkg::SUM_W-1){1'b1}}};
        end
    end

    // Sensor and steering limit comparisons.
    always_comb
    begin
        angle_ext     = EXT_W'(in_angle);
        white_new     = in_light < cfg.threshold;
        can_left_new  = angle_ext > -signed'({2'b00, cfg.max_left});
        can_right_new = angle_ext < signed'({2'b00, cfg.max_right});
    end

    // Load the beat; the PID history moves only in PID modes.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            e_reg         <= e_new;
            diff_reg      <= diff_new;
            white_reg     <= white_new;
            can_left_reg  <= can_left_new;
            can_right_reg <= can_right_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            sum_reg  <= '0;
        end
        else if (cmd.load && is_pid)
        begin
            prev_reg <= e_new;
            sum_reg  <= sum_sat;
        end
    end

    // Shared gain multiplier, product registered.
    always_comb
    begin
        case (cmd.mul_sel)
            lfsp_pkg::MUL_P:
            begin
                mul_a = signed'({9'd0, cfg.gain_p});
                mul_b = lfsp_pkg::MUL_B_W'(e_reg);
            end
            lfsp_pkg::MUL_I:
            begin
                mul_a = signed'({1'b0, cfg.gain_i});
                mul_b = sum_reg;
            end
            lfsp_pkg::MUL_D:
            begin
                mul_a = signed'({9'd0, cfg.gain_d});
                mul_b = lfsp_pkg::MUL_B_W'(diff_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg       <= mul_p;
            prod_shift_reg <= cmd.mul_sel != lfsp_pkg::MUL_I;
        end
    end

    // Accumulate the three terms; proportional and derivative go up by 16 bits.
    always_comb
    begin
        prod_wide = lfsp_pkg::ACC_W'(prod_reg);
        prod_term = prod_shift_reg ? (prod_wide <<< lfsp_pkg::GAIN_SH) : prod_wide;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clear)
        begin
            acc_reg <= prod_term;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + prod_term;
        end
    end

    // Negate for the left edge and clamp the turn to +-65536.0.
    always_comb
    begin
        turn_lim = lfsp_pkg::ACC_W'(lfsp_pkg::TURN_LIM);
        turn_pre = (cfg.mode == lfsp_pkg::MODE_PID_L) ? -acc_reg : acc_reg;
        if (turn_pre > turn_lim)
        begin
            turn_clamped = turn_lim;
        end
        else if (turn_pre < -turn_lim)
        begin
            turn_clamped = -turn_lim;
        end
        else
        begin
            turn_clamped = turn_pre;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clamp)
        begin
            turn_reg <= turn_clamped[lfsp_pkg::TURN_W-1:0];
        end
    end

    // Steering command scale by a constant.
    assign scale_c = signed'({1'b0, lfsp_pkg::SCALE_W'(lfsp_pkg::TURN_SCALE)});

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            scaled_reg <= turn_reg * scale_c;
        end
    end

    // Front steering value: truncate toward zero, saturate to 16 bits.
    always_comb
    begin
        front_adj = scaled_reg
                  + (scaled_reg[lfsp_pkg::SCALED_W-1]
                     ? lfsp_pkg::SCALED_W'((64'd1 << lfsp_pkg::FRAC_W) - 64'd1)
                     : lfsp_pkg::SCALED_W'(0));
        front_q   = FQ_W'(front_adj >>> lfsp_pkg::FRAC_W);
        if (front_q > FQ_W'(32767))
        begin
            front_sat = 16'sh7FFF;
        end
        else if (front_q < -FQ_W'(32768))
        begin
            front_sat = 16'sh8000;
        end
        else
        begin
            front_sat = front_q[lfsp_pkg::FRONT_W-1:0];
        end
    end

    // Corrected wheel PWM: base speed plus or minus the turn, toward zero, saturated.
    assign steer_left = white_reg ^ left_edge;

    always_comb
    begin
        pwm_t   = steer_left ? lfsp_pkg::PWMV_W'(turn_reg) : -lfsp_pkg::PWMV_W'(turn_reg);
        pwm_v   = (lfsp_pkg::PWMV_W'(cfg.base_speed) <<< lfsp_pkg::FRAC_W) + pwm_t;
        pwm_adj = pwm_v
                + (pwm_v[lfsp_pkg::PWMV_W-1]
                   ? lfsp_pkg::PWMV_W'((64'd1 << lfsp_pkg::FRAC_W) - 64'd1)
                   : lfsp_pkg::PWMV_W'(0));
        pwm_q   = PQ_W'(pwm_adj >>> lfsp_pkg::FRAC_W);
        if (pwm_q > PQ_W'(127))
        begin
            pwm_sat = 8'sh7F;
        end
        else if (pwm_q < -PQ_W'(128))
        begin
            pwm_sat = 8'sh80;
        end
        else
        begin
            pwm_sat = pwm_q[lfsp_pkg::SPEED_W-1:0];
        end
    end

    // Result selection per mode.
    always_comb
    begin
        kind_next  = 1'b0;
        front_next = '0;
        left_next  = '0;
        right_next = '0;
        if (!is_pid)
        begin
            if (steer_left)
            begin
                front_next = can_left_reg ? -lfsp_pkg::FRONT_W'(lfsp_pkg::FRONT_PWM) : '0;
                right_next = cfg.base_speed;
            end
            else
            begin
                front_next = can_right_reg ? lfsp_pkg::FRONT_W'(lfsp_pkg::FRONT_PWM) : '0;
                left_next  = cfg.base_speed;
            end
        end
        else
        begin
            kind_next  = steer_left ? can_left_reg : can_right_reg;
            front_next = kind_next ? front_sat : '0;
            if (steer_left)
            begin
                right_next = pwm_sat;
                left_next  = cfg.base_speed;
            end
            else
            begin
                left_next  = pwm_sat;
                right_next = cfg.base_speed;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            kind_reg  <= kind_next;
            front_reg <= front_next;
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign out_data = {right_reg, left_reg, front_reg};
    assign out_kind = kind_reg;

endmodule

`default_nettype wire

// ----- rtl/line_follow_steering_pid.sv -----
// Top level of the line-follow steering controller with PID and on-off modes.
//
// Usage: one input beat per sensor tick on the s_axis group carries the light
// sample and the front wheel angle; one output beat on the m_axis group carries
// the front value, its kind in tuser, and the left and right wheel PWM values.
// Registers are written through cfg_we/cfg_index/cfg_wdata while no beat is in
// flight; a write takes effect at the same clock edge.
// Sequence: an accepted beat takes the P, I and D multiply steps in turn on the single
// shared 25x32 gain multiplier, then the accumulate, clamp, scale and done steps of
// the sequencer; no new beat is accepted until the sequencer is idle again.
// The output register lets the next beat be accepted while a result waits; if
// the receiver keeps tready low, the sequencer holds in its last step and no
// further beat is accepted until the waiting result is taken.
// Reset clears the previous error and the error sum, loads the register reset
// values (PID right-edge mode, threshold 512) and empties the output register.
`default_nettype none

module line_follow_steering_pid (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Input stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [lfsp_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [9:0] light_sample, [25:10] wheel_angle
    // Output stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [lfsp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // [15:0] front_value, [23:16] left_pwm, [31:24] right_pwm
    output logic                                 m_axis_tuser,   // [0] front_kind
    // Register write port
    input  wire logic                            cfg_we,
    input  wire logic [lfsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lfsp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    lfsp_pkg::cfg_t    cfg;
    lfsp_pkg::dp_cmd_t cmd;

    lfsp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lfsp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd)
    );

    lfsp_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata),
        .out_kind (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- dv/line_follow_steering_pid_checker.sv -----
// Checker for the steering controller: predicts each result beat and compares it.
`timescale 1ns / 100ps

module line_follow_steering_pid_checker
    import lfsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [9:0] light_sample, [25:10] wheel_angle
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] front_value, [23:16] left_pwm, [31:24] right_pwm
    input  logic                  m_axis_tuser,   // [0] front_kind
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatches,
    output int                    steer_pending,
    output int                    samples_taken,
    output int                    commands_seen
);

    typedef struct {
        logic               kind;
        logic signed [15:0] front;
        logic signed [7:0]  left;
        logic signed [7:0]  right;
    } steer_cmd_t;

    localparam longint Q24_ONE = 64'sd1 <<< 24;

    // Register copy and controller history as the block should hold them.
    cfg_t               regs;
    logic signed [10:0] last_err;
    logic signed [31:0] err_total;
    steer_cmd_t         predicted_steer[$];

    function automatic longint drop_frac(longint x);
        if (x < 0)
            return -((-x) >>> 24);
        return x >>> 24;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Wheel speed with a turn correction added, truncated and held to 8 bits.
    function automatic logic signed [7:0] wheel_pwm(longint speed, longint turn);
        return 8'(clip(drop_frac(speed * Q24_ONE + turn), -128, 127));
    endfunction

    // Works out the command for one sensor tick and advances the PID history.
    function automatic steer_cmd_t predict_steer(logic [9:0] light, logic signed [15:0] angle);
        steer_cmd_t cmd;
        int         lum;
        int         ang;
        int         speed;
        int         err;
        bit         white;
        bit         can_l;
        bit         can_r;
        bit         go_left;
        bit         allowed;
        longint     turn;
        lum   = int'(light);
        ang   = int'(angle);
        speed = int'(regs.base_speed);
        white = lum < int'(regs.threshold);
        can_l = ang > -int'(regs.max_left);
        can_r = ang < int'(regs.max_right);
        cmd.kind  = 1'b0;
        cmd.front = '0;
        cmd.left  = '0;
        cmd.right = '0;
        if (regs.mode == MODE_ONOFF_R || regs.mode == MODE_ONOFF_L)
        begin
            // Bang-bang steering; the wheel on the side of the turn is stopped.
            go_left = (regs.mode == MODE_ONOFF_R) ? white : !white;
            if (go_left)
            begin
                cmd.front = can_l ? 16'(-FRONT_PWM) : '0;
                cmd.right = 8'(speed);
            end
            else
            begin
                cmd.front = can_r ? 16'(FRONT_PWM) : '0;
                cmd.left  = 8'(speed);
            end
        end
        else
        begin
            // PID with a trapezoidal sum; gains are Q8.8 except the integral, Q0.24.
            err       = lum - int'(regs.threshold);
            err_total = 32'(clip(longint'(err_total) + err + last_err,
                                 -64'sd2147483648, 64'sd2147483647));
            turn = longint'(regs.gain_p) * err * 65536
                 + longint'(regs.gain_i) * longint'(err_total)
                 + longint'(regs.gain_d) * (err - last_err) * 65536;
            last_err = 11'(err);
            if (regs.mode == MODE_PID_L)
                turn = -turn;
            turn = clip(turn, -TURN_LIM, TURN_LIM);

            if (regs.mode == MODE_PID_R)
                allowed = white ? can_l : can_r;
            else
                allowed = white ? can_r : can_l;
            if (allowed)
            begin
                cmd.kind  = 1'b1;
                cmd.front = 16'(clip(drop_frac(turn * TURN_SCALE), -32768, 32767));
            end

            if ((regs.mode == MODE_PID_R) == white)
            begin
                cmd.right = wheel_pwm(speed, turn);
                cmd.left  = 8'(speed);
            end
            else
            begin
                cmd.left  = wheel_pwm(speed, -turn);
                cmd.right = 8'(speed);
            end
        end
        return cmd;
    endfunction

    // Track register writes, predict on each input beat, compare each output beat.
    always @(posedge clk or negedge rst_n)
    begin
        steer_cmd_t want;
        steer_cmd_t got;
        if (!rst_n)
        begin
            regs.mode       = MODE_PID_R;
            regs.threshold  = 10'd512;
            regs.base_speed = '0;
            regs.max_left   = '0;
            regs.max_right  = '0;
            regs.gain_p     = 16'd64;
            regs.gain_i     = '0;
            regs.gain_d     = 16'd1600;
            last_err        = '0;
            err_total       = '0;
            predicted_steer.delete();
            mismatches      = 0;
            samples_taken   = 0;
            commands_seen   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_MODE:      regs.mode       = mode_t'(cfg_wdata[1:0]);
                    REG_THRESHOLD: regs.threshold  = cfg_wdata[9:0];
                    REG_BASE:      regs.base_speed = cfg_wdata[7:0];
                    REG_MAX_LEFT:  regs.max_left   = cfg_wdata[14:0];
                    REG_MAX_RIGHT: regs.max_right  = cfg_wdata[14:0];
                    REG_GAIN_P:    regs.gain_p     = cfg_wdata[15:0];
                    REG_GAIN_I:    regs.gain_i     = cfg_wdata[23:0];
                    REG_GAIN_D:    regs.gain_d     = cfg_wdata[15:0];
                    default: ;
                endcase
            end

            // An output beat always belongs to an older input beat, so compare first.
            if (m_axis_tvalid && m_axis_tready)
            begin
                commands_seen++;
                got.kind  = m_axis_tuser;
                got.front = m_axis_tdata[15:0];
                got.left  = m_axis_tdata[23:16];
                got.right = m_axis_tdata[31:24];
                if (predicted_steer.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("[%0t] unexpected output beat: kind %0d front %0d left %0d right %0d",
                                 $time, got.kind, got.front, got.left, got.right);
                    mismatches++;
                end
                else
                begin
                    want = predicted_steer.pop_front();
                    if (got.kind !== want.kind || got.front !== want.front ||
                        got.left !== want.left || got.right !== want.right)
                    begin
                        if (mismatches < 10)
                            $display("[%0t] mismatch: expected kind %0d front %0d left %0d right %0d, got kind %0d front %0d left %0d right %0d",
                                     $time, want.kind, want.front, want.left, want.right,
                                     got.kind, got.front, got.left, got.right);
                        mismatches++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                samples_taken++;
                predicted_steer.push_back(predict_steer(s_axis_tdata[9:0], s_axis_tdata[25:10]));
            end
        end
        steer_pending = predicted_steer.size();
    end

endmodule

// ----- dv/line_follow_steering_pid_test.sv -----
// Top of the steering controller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module line_follow_steering_pid_test;
    import lfsp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;    // [9:0] light_sample, [25:10] wheel_angle
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;          // [15:0] front_value, [23:16] left_pwm, [31:24] right_pwm
    logic                  m_axis_tuser;          // [0] front_kind
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    int mismatches;
    int steer_pending;
    int samples_taken;
    int commands_seen;
    int cycle_count = 0;
    int settings    = 0;
    bit calm        = 1'b0;

    line_follow_steering_pid DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    line_follow_steering_pid_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .steer_pending (steer_pending),
        .samples_taken (samples_taken),
        .commands_seen (commands_seen)
    );

    always #4 clk = ~clk;

    // Receiver back-pressure, absent while the calm flag is set.
    always @(negedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 14);
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, steer_pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Register write with random junk above the register's own width; leaves cfg_we high.
    task automatic set_reg(reg_idx_t idx, int value);
        int          width;
        logic [23:0] keep;
        case (idx)
            REG_MODE:                 width = 2;
            REG_THRESHOLD:            width = 10;
            REG_BASE:                 width = 8;
            REG_MAX_LEFT, REG_MAX_RIGHT: width = 15;
            REG_GAIN_I:               width = 24;
            default:                  width = 16;
        endcase
        keep = 24'((32'd1 << width) - 1);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= (24'(value) & keep) | (24'($urandom) & ~keep);
        @(negedge clk);
    endtask

    // Let every result drain, then wait out the pipeline before touching registers.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (steer_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic load_config(int mode, int thr, int base, int max_l, int max_r,
                               int gp, int gi, int gd);
        drain();
        set_reg(REG_MODE, mode);
        set_reg(REG_THRESHOLD, thr);
        set_reg(REG_BASE, base);
        set_reg(REG_MAX_LEFT, max_l);
        set_reg(REG_MAX_RIGHT, max_r);
        set_reg(REG_GAIN_P, gp);
        set_reg(REG_GAIN_I, gi);
        set_reg(REG_GAIN_D, gd);
        cfg_we <= 1'b0;
        @(negedge clk);
        settings++;
    endtask

    // Sends one sensor beat; returns at the falling edge after it was taken.
    task automatic send_sample(int light, int angle);
        while (!calm && $urandom_range(0, 99) < 14)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, 16'(angle), 10'(light)};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic int pick_limit();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 32767;
            2:       return $urandom_range(0, 2000);
            default: return $urandom_range(0, 32767);
        endcase
    endfunction

    function automatic int clamp_int(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // One phase of random settings and sensor beats, mostly near the threshold and limits.
    task automatic random_phase(int count, bit hold_midway);
        int thr;
        int max_l;
        int max_r;
        int light;
        int angle;
        int n;
        case ($urandom_range(0, 3))
            0:       thr = 0;
            1:       thr = 1023;
            default: thr = $urandom_range(0, 1023);
        endcase
        max_l = pick_limit();
        max_r = pick_limit();
        load_config($urandom_range(0, 3), thr, $urandom_range(0, 255), max_l, max_r,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 600),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16777215) : $urandom_range(0, 20000),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2000));
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 2) == 0)
                light = $urandom_range(0, 1023);
            else
                light = clamp_int(thr + $urandom_range(0, 80) - 40, 0, 1023);
            case ($urandom_range(0, 2))
                0:       angle = int'($signed(16'($urandom)));
                1:       angle = clamp_int(-max_l + $urandom_range(0, 6) - 3, -32768, 32767);
                default: angle = clamp_int(max_r + $urandom_range(0, 6) - 3, -32768, 32767);
            endcase
            // In the hold phase the sender holds off midway until the block has handed back every result.
            if (hold_midway && n == count / 2)
                drain();
            send_sample(light, angle);
        end
    endtask

    initial
    begin
        int p;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: PID right edge, zero limits, so angle zero sits at both limits.
        send_sample(0, 0);
        send_sample(1023, 32767);
        send_sample(512, -32768);
        send_sample(511, 1);
        send_sample(1023, -1);

        // On-off right edge at full forward speed, samples on both sides of the limits.
        load_config(MODE_ONOFF_R, 300, 127, 1000, 1000, 0, 0, 0);
        send_sample(299, 0);
        send_sample(300, 0);
        send_sample(0, -1000);
        send_sample(1023, 1000);
        send_sample(0, -999);
        send_sample(1023, 999);

        // On-off left edge, full reverse, everything reads black.
        load_config(MODE_ONOFF_L, 0, -128, 32767, 32767, 65535, 16777215, 65535);
        send_sample(0, 0);
        send_sample(1023, -32768);
        send_sample(1023, 32767);

        // PID left edge with every gain at full scale: outputs saturate both ways.
        load_config(MODE_PID_L, 1023, -128, 32767, 32767, 65535, 16777215, 65535);
        send_sample(0, -32768);
        send_sample(1023, 32767);
        send_sample(0, 0);
        send_sample(1023, 0);
        send_sample(0, 100);

        // PID right edge with zero gains: the turn is zero, wheels at base speed.
        load_config(MODE_PID_R, 512, 127, 32767, 0, 0, 0, 0);
        send_sample(0, -32767);
        send_sample(1023, -1);
        send_sample(700, 0);

        // Random settings; one phase runs without any idling on either side.
        for (p = 0; p < 8; p++)
        begin
            calm = (p == 2);
            random_phase(100, p == 4);
        end
        calm = 1'b0;

        drain();
        $display("Sent %0d sensor beats and checked %0d command beats over %0d register settings.",
                 samples_taken, commands_seen, settings);
        $display("Covered on-off and PID modes for both line edges, limits and saturation.");
        if (mismatches == 0 && steer_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
